FILE: hw/rtl/vtta_pkg.sv
// ----------------------------------------------------------------------------
// vtta_pkg
// Shared types, constants and helper functions for the VGA text to ANSI
// stream unit: grid size, cell descriptor, byte sequencer segments.
// ----------------------------------------------------------------------------
package vtta_pkg;

    // Text grid
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam logic [7:0] COL_LAST = 8'(COLUMNS - 1);
    localparam logic [7:0] ROW_LAST = 8'(ROWS - 1);

    // Stream widths
    localparam int S_DATA_W = 40;
    localparam int CELL_W   = 16;

    // Cursor cell divided by COLUMNS through a scaled reciprocal
    localparam int DIV_SHIFT = 24;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int DIV_RECIP = (2 ** DIV_SHIFT) / COLUMNS;
    localparam int PROD_W    = CELL_W + RECIP_W;

    // Cell queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Characters
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Classified cell, one queue entry
    typedef struct packed {
        logic              home;
        logic              color;
        logic [3:0]        fg;
        logic [3:0]        bg;
        logic [7:0]        ch;
        logic              crlf;
        logic              frame_end;
        logic              cur_ok;
        logic [CELL_W-1:0] cursor_idx;
    } cell_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Byte sequencer segments, in emission order
    typedef enum logic [3:0] {
        SEG_HOME,
        SEG_FG_PRE,
        SEG_FG_DIG,
        SEG_BG_PRE,
        SEG_BG_DIG,
        SEG_BG_END,
        SEG_CHAR,
        SEG_CRLF,
        SEG_RST,
        SEG_CUP_PRE,
        SEG_ROW_DIG,
        SEG_SEMI,
        SEG_COL_DIG,
        SEG_CUP_END,
        SEG_DONE
    } seg_t;

    // VGA colour index to ANSI 256-colour index
    function automatic logic [3:0] colour_map(input logic [3:0] idx);
        logic [3:0] res;
        case (idx)
            4'd0:    res = 4'd0;
            4'd1:    res = 4'd4;
            4'd2:    res = 4'd2;
            4'd3:    res = 4'd6;
            4'd4:    res = 4'd1;
            4'd5:    res = 4'd5;
            4'd6:    res = 4'd3;
            4'd7:    res = 4'd7;
            4'd8:    res = 4'd8;
            4'd9:    res = 4'd12;
            4'd10:   res = 4'd10;
            4'd11:   res = 4'd14;
            4'd12:   res = 4'd9;
            4'd13:   res = 4'd13;
            4'd14:   res = 4'd11;
            default: res = 4'd15;
        endcase
        return res;
    endfunction

    // Double dabble, 8-bit binary to three BCD digits
    function automatic logic [11:0] bin_to_bcd(input logic [7:0] v);
        logic [19:0] sh;
        sh = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (sh[11:8] >= 4'd5) begin
                sh[11:8] = sh[11:8] + 4'd3;
            end
            if (sh[15:12] >= 4'd5) begin
                sh[15:12] = sh[15:12] + 4'd3;
            end
            if (sh[19:16] >= 4'd5) begin
                sh[19:16] = sh[19:16] + 4'd3;
            end
            sh = {sh[18:0], 1'b0};
        end
        return sh[19:8];
    endfunction

    // Number of printed digits, no leading zeros
    function automatic logic [1:0] digit_count(input logic [11:0] bcd);
        logic [1:0] n;
        if (bcd[11:8] != 4'd0) begin
            n = 2'd3;
        end else if (bcd[7:4] != 4'd0) begin
            n = 2'd2;
        end else begin
            n = 2'd1;
        end
        return n;
    endfunction

    // ASCII digit at position idx, most significant first
    function automatic logic [7:0] digit_char(input logic [11:0] bcd, input logic [1:0] n,
                                              input logic [2:0] idx);
        logic [1:0] pos;
        logic [3:0] d;
        pos = n - 2'd1 - idx[1:0];
        case (pos)
            2'd0:    d = bcd[3:0];
            2'd1:    d = bcd[7:4];
            default: d = bcd[11:8];
        endcase
        return CH_ZERO + {4'd0, d};
    endfunction

    // Fixed text of a segment
    function automatic logic [7:0] fixed_text(input seg_t seg, input logic [2:0] idx);
        logic [7:0] b;
        b = CH_SPACE;
        case (seg)
            SEG_HOME: begin
                case (idx)
                    3'd0:    b = CH_ESC;
                    3'd1:    b = "[";
                    default: b = "H";
                endcase
            end
            SEG_FG_PRE: begin
                case (idx)
                    3'd0:    b = CH_ESC;
                    3'd1:    b = "[";
                    3'd2:    b = "3";
                    3'd3:    b = "8";
                    3'd4:    b = ";";
                    3'd5:    b = "5";
                    default: b = ";";
                endcase
            end
            SEG_BG_PRE: begin
                case (idx)
                    3'd0:    b = "m";
                    3'd1:    b = CH_ESC;
                    3'd2:    b = "[";
                    3'd3:    b = "4";
                    3'd4:    b = "8";
                    3'd5:    b = ";";
                    3'd6:    b = "5";
                    default: b = ";";
                endcase
            end
            SEG_BG_END: b = "m";
            SEG_CRLF:   b = (idx == 3'd0) ? CH_CR : CH_LF;
            SEG_RST: begin
                case (idx)
                    3'd0:    b = CH_ESC;
                    3'd1:    b = "[";
                    3'd2:    b = "0";
                    default: b = "m";
                endcase
            end
            SEG_CUP_PRE: b = (idx == 3'd0) ? CH_ESC : 8'("[");
            SEG_SEMI:    b = ";";
            SEG_CUP_END: begin
                case (idx)
                    3'd0:    b = "H";
                    3'd1:    b = CH_ESC;
                    3'd2:    b = "[";
                    3'd3:    b = "?";
                    3'd4:    b = "2";
                    3'd5:    b = "5";
                    default: b = "h";
                endcase
            end
            default: b = CH_SPACE;
        endcase
        return b;
    endfunction

    // Index of the last byte of a fixed segment
    function automatic logic [2:0] fixed_last(input seg_t seg);
        logic [2:0] n;
        case (seg)
            SEG_HOME:    n = 3'd2;
            SEG_FG_PRE:  n = 3'd6;
            SEG_BG_PRE:  n = 3'd7;
            SEG_CRLF:    n = 3'd1;
            SEG_RST:     n = 3'd3;
            SEG_CUP_PRE: n = 3'd1;
            SEG_CUP_END: n = 3'd6;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic seg_t first_seg(input cell_desc_t d);
        seg_t s;
        if (d.home) begin
            s = SEG_HOME;
        end else if (d.color) begin
            s = SEG_FG_PRE;
        end else begin
            s = SEG_CHAR;
        end
        return s;
    endfunction

    function automatic seg_t next_seg(input seg_t seg, input cell_desc_t d);
        seg_t s;
        case (seg)
            SEG_HOME:    s = d.color ? SEG_FG_PRE : SEG_CHAR;
            SEG_FG_PRE:  s = SEG_FG_DIG;
            SEG_FG_DIG:  s = SEG_BG_PRE;
            SEG_BG_PRE:  s = SEG_BG_DIG;
            SEG_BG_DIG:  s = SEG_BG_END;
            SEG_BG_END:  s = SEG_CHAR;
            SEG_CHAR: begin
                if (d.crlf) begin
                    s = SEG_CRLF;
                end else if (d.frame_end) begin
                    s = SEG_RST;
                end else begin
                    s = SEG_DONE;
                end
            end
            SEG_RST:     s = d.cur_ok ? SEG_CUP_PRE : SEG_DONE;
            SEG_CUP_PRE: s = SEG_ROW_DIG;
            SEG_ROW_DIG: s = SEG_SEMI;
            SEG_SEMI:    s = SEG_COL_DIG;
            SEG_COL_DIG: s = SEG_CUP_END;
            default:     s = SEG_DONE;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/vga_text_to_ansi_stream_unit.sv
// ----------------------------------------------------------------------------
// vga_text_to_ansi_stream_unit
// Converts row-major VGA text cells into the ANSI byte stream of one frame.
//
//   channel  dir  payload                                   handshake
//   s_       in   char_code, attr_byte, cursor_cell         s_tvalid / s_tready
//   m_       out  out_byte (tdata), run_last (tlast),       m_tvalid / m_tready
//                 frame_last (tuser)
//
// One output byte per cycle while m_tready is high. A plain cell causes one byte,
// a frame end up to 38; the byte sequencer emits them.
// A four-entry cell queue lets cells enter while longer runs drain.
// Reset (aresetn low, synchronous) clears position, attribute, queue and output.
// m_tready low holds the output byte; the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module vga_text_to_ansi_stream_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vtta_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] char_code, [15:8] attr_byte,
                                                     // [32:16] cursor_cell, [39:33] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    output logic                          m_tuser    // [0] frame_last
);
    import vtta_pkg::*;

    logic          push;
    logic          pop;
    cell_desc_t    push_desc;
    cell_desc_t    head_desc;
    queue_status_t q_status;

    vtta_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    vtta_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .q_status  (q_status)
    );

    vtta_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_desc (head_desc),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Frame end only ever marks the closing byte of a run
    a_frame_on_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_last without run_last");

    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("cell queue full and empty at once");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("cell queue popped while empty");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

FILE: hw/rtl/vtta_front.sv
// ----------------------------------------------------------------------------
// vtta_front
// Accepts text cells, tracks the grid position and the last attribute, and
// classifies each cell into a descriptor for the cell queue.
// ----------------------------------------------------------------------------
module vtta_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vtta_pkg::S_DATA_W-1:0]   s_tdata,   // char_code, attr_byte, cursor_cell
    input  vtta_pkg::queue_status_t         q_status,
    output logic                            push,
    output vtta_pkg::cell_desc_t            push_desc
);
    import vtta_pkg::*;

    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [7:0] prev_attr_reg, prev_attr_next;
    logic       attr_known_reg, attr_known_next;

    logic [7:0]  ch_in;
    logic [7:0]  attr_in;
    logic [16:0] cur_in;
    logic        home;
    logic        color;
    logic        row_end;
    logic        frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            prev_attr_reg  <= '0;
            attr_known_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            prev_attr_reg  <= prev_attr_next;
            attr_known_reg <= attr_known_next;
        end
    end

    always_comb begin
        ch_in     = s_tdata[7:0];
        attr_in   = s_tdata[15:8];
        cur_in    = s_tdata[32:16];
        home      = (col_reg == 8'd0) && (row_reg == 8'd0);
        color     = home || !attr_known_reg || (attr_in != prev_attr_reg);
        row_end   = col_reg >= COL_LAST;
        frame_end = row_end && (row_reg >= ROW_LAST);

        s_tready = !q_status.full;
        push     = s_tvalid && !q_status.full;

        push_desc.home       = home;
        push_desc.color      = color;
        push_desc.fg         = colour_map(attr_in[3:0]);
        push_desc.bg         = colour_map({1'b0, attr_in[6:4]});
        push_desc.ch         = ((ch_in < CH_SPACE) || (ch_in == CH_DEL)) ? CH_SPACE : ch_in;
        push_desc.crlf       = row_end && !frame_end;
        push_desc.frame_end  = frame_end;
        push_desc.cur_ok     = !cur_in[16] && (cur_in[15:0] < CELL_W'(CELLS));
        push_desc.cursor_idx = cur_in[15:0];

        col_next        = col_reg;
        row_next        = row_reg;
        prev_attr_next  = prev_attr_reg;
        attr_known_next = attr_known_reg;
        if (push) begin
            if (color) begin
                prev_attr_next = attr_in;
            end
            attr_known_next = 1'b1;
            if (frame_end) begin
                col_next        = '0;
                row_next        = '0;
                attr_known_next = 1'b0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row_reg + 8'd1;
            end else begin
                col_next = col_reg + 8'd1;
            end
        end
    end

endmodule

FILE: hw/rtl/vtta_fifo.sv
// ----------------------------------------------------------------------------
// vtta_fifo
// Short queue of classified cells between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module vtta_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  vtta_pkg::cell_desc_t    push_desc,
    input  logic                    pop,
    output vtta_pkg::cell_desc_t    head_desc,
    output vtta_pkg::queue_status_t q_status
);
    import vtta_pkg::*;

    cell_desc_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
        head_desc      = entry_reg[rd_ptr_reg];
        q_status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
        q_status.empty = count_reg == '0;
    end

endmodule

FILE: hw/rtl/vtta_back.sv
// ----------------------------------------------------------------------------
// vtta_back
// Byte sequencer: walks the segments of one cell descriptor and emits the
// terminal bytes through an output register. Also converts the cursor cell
// to row and column digits in a short register chain.
// ----------------------------------------------------------------------------
module vtta_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  vtta_pkg::cell_desc_t    head_desc,
    input  vtta_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,   // out_byte
    output logic                    m_tlast,
    output logic                    m_tuser    // frame_last
);
    import vtta_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(DIV_RECIP);
    localparam logic [CELL_W-1:0]  COL_W16 = CELL_W'(COLUMNS);
    localparam logic [8:0]         COL_W9  = 9'(COLUMNS);

    logic              cur_valid_reg, cur_valid_next;
    cell_desc_t        desc_reg, desc_next;
    seg_t              seg_reg, seg_next;
    logic [2:0]        idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [7:0]        quo_reg, quo_next;
    logic [7:0]        rem_reg, rem_next;
    logic [11:0]       row_bcd_reg, row_bcd_next;
    logic [11:0]       col_bcd_reg, col_bcd_next;

    logic [7:0]        qest;
    logic [CELL_W-1:0] rem_wide;
    logic [8:0]        rem9;
    logic [11:0]       fg_bcd;
    logic [7:0]        byte_val;
    logic              seg_last;
    seg_t              seg_after;
    logic              run_done;
    logic              emit;
    logic              load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            seg_reg       <= SEG_DONE;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            seg_reg       <= seg_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg    <= desc_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_user_reg  <= m_user_next;
        prod_reg    <= prod_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        row_bcd_reg <= row_bcd_next;
        col_bcd_reg <= col_bcd_next;
    end

    // Cursor: product, corrected quotient/remainder, then BCD, each registered. The
    // chain settles after a load, well before the row digits are reached.
    always_comb begin
        prod_next = PROD_W'(desc_reg.cursor_idx) * PROD_W'(RECIP_C);
        qest      = prod_reg[DIV_SHIFT +: 8];
        rem_wide  = desc_reg.cursor_idx - CELL_W'(CELL_W'(qest) * COL_W16);
        rem9      = rem_wide[8:0];
        if (rem9 >= COL_W9) begin
            quo_next = qest + 8'd1;
            rem_next = 8'(rem9 - COL_W9);
        end else begin
            quo_next = qest;
            rem_next = rem9[7:0];
        end
        row_bcd_next = bin_to_bcd(quo_reg + 8'd1);
        col_bcd_next = bin_to_bcd(rem_reg + 8'd1);
    end

    always_comb begin
        fg_bcd = bin_to_bcd({4'd0, desc_reg.fg});

        unique case (seg_reg)
            SEG_FG_DIG: begin
                byte_val = digit_char(fg_bcd, digit_count(fg_bcd), idx_reg);
                seg_last = idx_reg[1:0] == digit_count(fg_bcd) - 2'd1;
            end
            SEG_BG_DIG: begin
                byte_val = CH_ZERO + {4'd0, desc_reg.bg};
                seg_last = 1'b1;
            end
            SEG_CHAR: begin
                byte_val = desc_reg.ch;
                seg_last = 1'b1;
            end
            SEG_ROW_DIG: begin
                byte_val = digit_char(row_bcd_reg, digit_count(row_bcd_reg), idx_reg);
                seg_last = idx_reg[1:0] == digit_count(row_bcd_reg) - 2'd1;
            end
            SEG_COL_DIG: begin
                byte_val = digit_char(col_bcd_reg, digit_count(col_bcd_reg), idx_reg);
                seg_last = idx_reg[1:0] == digit_count(col_bcd_reg) - 2'd1;
            end
            default: begin
                byte_val = fixed_text(seg_reg, idx_reg);
                seg_last = idx_reg == fixed_last(seg_reg);
            end
        endcase

        seg_after = next_seg(seg_reg, desc_reg);
        run_done  = seg_last && (seg_after == SEG_DONE);
        emit      = cur_valid_reg && (!m_valid_reg || m_tready);
        load      = !q_status.empty && (!cur_valid_reg || (emit && run_done));
        pop       = load;

        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        cur_valid_next = cur_valid_reg;
        desc_next      = desc_reg;
        seg_next       = seg_reg;
        idx_next       = idx_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = byte_val;
            m_last_next  = run_done;
            m_user_next  = run_done && desc_reg.frame_end;
            if (seg_last) begin
                if (run_done) begin
                    cur_valid_next = 1'b0;
                    seg_next       = SEG_DONE;
                end else begin
                    seg_next = seg_after;
                end
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        // Take the next cell in the same cycle the previous run finishes
        if (load) begin
            cur_valid_next = 1'b1;
            desc_next      = head_desc;
            seg_next       = first_seg(head_desc);
            idx_next       = '0;
        end

        m_tvalid = m_valid_reg;
        m_tdata  = m_data_reg;
        m_tlast  = m_last_reg;
        m_tuser  = m_user_reg;
    end

endmodule

FILE: dv/vga_text_to_ansi_stream_unit_checker.sv
// ----------------------------------------------------------------------------
// vga_text_to_ansi_stream_unit_checker
// Watches both stream channels of the VGA text to ANSI unit. It renders every
// accepted cell into the terminal bytes it must cause, queues them in order
// and compares each output transaction with the oldest queued byte.
// ----------------------------------------------------------------------------
module vga_text_to_ansi_stream_unit_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [vtta_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] char_code, [15:8] attr_byte,
                                                     // [32:16] cursor_cell, [39:33] zero
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,   // [7:0] out_byte
    input  logic                          m_tlast,
    input  logic                          m_tuser,   // [0] frame_last
    output int                            mismatch_count,
    output int                            pending_bytes
);

    localparam logic [7:0]  ESC         = 8'h1B;
    localparam logic [7:0]  DIGIT_ZERO  = 8'h30;
    // VGA colour index to ANSI index, entry n in nibble n
    localparam logic [63:0] COLOR_LUT   = 64'hFBD9_EAC8_7351_6240;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       frame_end;
    } stream_byte_t;

    stream_byte_t expected_bytes[$];
    logic [7:0]   run_bytes[$];
    int           column_pos;
    int           row_pos;
    logic [7:0]   seen_attr;
    bit           attr_valid;

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            run_bytes.push_back(s[i]);
        end
    endtask

    // Decimal without leading zeros
    task automatic push_decimal(input int v);
        if (v >= 100) begin
            run_bytes.push_back(DIGIT_ZERO + 8'(v / 100));
        end
        if (v >= 10) begin
            run_bytes.push_back(DIGIT_ZERO + 8'((v / 10) % 10));
        end
        run_bytes.push_back(DIGIT_ZERO + 8'(v % 10));
    endtask

    task automatic render_cell(input logic [7:0] ch, input logic [7:0] attr, input int cursor);
        logic [7:0]   glyph;
        bit           row_end;
        bit           frame_end;
        stream_byte_t entry;
        run_bytes.delete();
        if (column_pos == 0 && row_pos == 0) begin
            attr_valid = 1'b0;
            run_bytes.push_back(ESC);
            push_text("[H");
        end
        // bit 7 takes part in the change test but never in the colour codes
        if (!attr_valid || attr != seen_attr) begin
            run_bytes.push_back(ESC);
            push_text("[38;5;");
            push_decimal(COLOR_LUT[attr[3:0] * 4 +: 4]);
            push_text("m");
            run_bytes.push_back(ESC);
            push_text("[48;5;");
            push_decimal(COLOR_LUT[attr[6:4] * 4 +: 4]);
            push_text("m");
            seen_attr  = attr;
            attr_valid = 1'b1;
        end
        glyph = (ch < 8'h20 || ch == 8'h7F) ? 8'h20 : ch;
        run_bytes.push_back(glyph);
        row_end   = (column_pos + 1 >= vtta_pkg::COLUMNS);
        frame_end = row_end && (row_pos + 1 >= vtta_pkg::ROWS);
        if (row_end && !frame_end) begin
            run_bytes.push_back(8'h0D);
            run_bytes.push_back(8'h0A);
        end
        if (frame_end) begin
            run_bytes.push_back(ESC);
            push_text("[0m");
            if (cursor >= 0 && cursor < vtta_pkg::COLUMNS * vtta_pkg::ROWS) begin
                run_bytes.push_back(ESC);
                push_text("[");
                push_decimal(cursor / vtta_pkg::COLUMNS + 1);
                push_text(";");
                push_decimal(cursor % vtta_pkg::COLUMNS + 1);
                push_text("H");
                run_bytes.push_back(ESC);
                push_text("[?25h");
            end
            column_pos = 0;
            row_pos    = 0;
            attr_valid = 1'b0;
        end else if (row_end) begin
            column_pos = 0;
            row_pos    = (row_pos + 1) & 8'hFF;
        end else begin
            column_pos = (column_pos + 1) & 8'hFF;
        end
        for (int k = 0; k < run_bytes.size(); k++) begin
            entry.data      = run_bytes[k];
            entry.run_end   = (k == run_bytes.size() - 1);
            entry.frame_end = entry.run_end && frame_end;
            expected_bytes.push_back(entry);
        end
    endtask

    task automatic count_mismatch(input string detail);
        if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: mismatch: %s", $time, detail);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : watch
        stream_byte_t seen;
        stream_byte_t want;
        if (!aresetn) begin
            expected_bytes.delete();
            column_pos     = 0;
            row_pos        = 0;
            seen_attr      = 8'h00;
            attr_valid     = 1'b0;
            mismatch_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                render_cell(s_tdata[7:0], s_tdata[15:8], $signed(s_tdata[32:16]));
            end
            if (m_tvalid && m_tready) begin
                seen = {m_tdata, m_tlast, m_tuser};
                if (expected_bytes.size() == 0) begin
                    count_mismatch($sformatf("unexpected byte %02h last %b frame_last %b",
                                             seen.data, seen.run_end, seen.frame_end));
                end else begin
                    want = expected_bytes.pop_front();
                    if (seen !== want) begin
                        count_mismatch($sformatf(
                            "expected byte %02h last %b frame_last %b, got %02h %b %b",
                            want.data, want.run_end, want.frame_end,
                            seen.data, seen.run_end, seen.frame_end));
                    end
                end
            end
        end
        pending_bytes = expected_bytes.size();
    end

endmodule

FILE: dv/tb_vga_text_to_ansi_stream_unit.sv
// ----------------------------------------------------------------------------
// tb_vga_text_to_ansi_stream_unit
// Drives row-major text cells into the VGA text to ANSI unit: a directed
// opening (character extremes, control codes, bit-7-only attribute changes,
// every colour), then random cells with runs of repeated attributes, across
// several row breaks. Frame-end cursor cells lie in and beyond the grid,
// but no frame ends in the run. Both sides idle in random bursts except in
// the last stretch of the run; a checker does the compare.
// ----------------------------------------------------------------------------
module tb_vga_text_to_ansi_stream_unit;

    localparam int ITEMS          = 270;
    localparam int QUIET_ITEMS    = 40;
    localparam int GRID_CELLS     = vtta_pkg::COLUMNS * vtta_pkg::ROWS;
    localparam int DIRECTED_CELLS = 25;
    localparam int DRAIN_CYCLES   = 64;
    localparam int TIME_LIMIT     = 30_000_000;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [vtta_pkg::S_DATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;
    int                            mismatch_count;
    int                            pending_bytes;
    bit                            idle_enable;

    vga_text_to_ansi_stream_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    vga_text_to_ansi_stream_unit_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_bytes  (pending_bytes)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIME_LIMIT);
        $display("vga_text_to_ansi_stream_unit verification failed");
        $finish;
    end

    // Output backpressure: random stall bursts while idling is enabled
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left == 0 && idle_enable && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one cell and hold it until the transaction completes
    task automatic send_cell(input logic [7:0] ch, input logic [7:0] attr,
                             input logic [16:0] cursor);
        if (idle_enable && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, cursor, attr, ch};
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [16:0] cursor;
        int          k;
        int          f;
        idle_enable = 1'b1;
        attr        = 8'h07;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < ITEMS; n++) begin
            // k: cell within the frame, f: frame number
            k = n % GRID_CELLS;
            f = n / GRID_CELLS;
            idle_enable = (n < ITEMS - QUIET_ITEMS);
            if (f == 0 && k < DIRECTED_CELLS) begin
                case (k)
                    0:       {attr, ch} = {8'h07, 8'h41};
                    1:       {attr, ch} = {8'h07, 8'h00};  // control code, same attribute
                    2:       {attr, ch} = {8'h07, 8'h1F};
                    3:       {attr, ch} = {8'h87, 8'h7F};  // only bit 7 changes
                    4:       {attr, ch} = {8'h87, 8'h20};
                    5:       {attr, ch} = {8'h00, 8'h7E};
                    6:       {attr, ch} = {8'hFF, 8'h80};
                    7:       {attr, ch} = {8'hFF, 8'hFF};
                    8:       {attr, ch} = {8'h7F, 8'h0A};
                    default: begin
                        // sweep every foreground and background colour
                        attr = {1'b0, 3'(k - 9), 4'(k - 9)};
                        ch   = 8'(8'h40 + k);
                    end
                endcase
            end else begin
                // mostly runs of one attribute, occasionally a new one
                if ($urandom_range(0, 9) == 0) begin
                    attr = ($urandom_range(0, 3) == 0) ? (attr ^ 8'h80) : 8'($urandom);
                end
                if ($urandom_range(0, 3) == 0) begin
                    ch = ($urandom_range(0, 4) == 0) ? 8'h7F : 8'($urandom_range(0, 31));
                end else begin
                    ch = 8'($urandom);
                end
            end
            if (k == GRID_CELLS - 1) begin
                case (f)
                    0:       cursor = 17'(GRID_CELLS - 1);
                    1:       cursor = 17'h1FFFF;           // minus one
                    2:       cursor = 17'd0;
                    3:       cursor = 17'(GRID_CELLS);     // first cell past the grid
                    4:       cursor = 17'($urandom_range(0, GRID_CELLS - 1));
                    5:       cursor = 17'h10000;           // most negative
                    default: cursor = 17'h0FFFF;           // largest positive
                endcase
            end else begin
                cursor = 17'($urandom);
            end
            send_cell(ch, attr, cursor);
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_bytes != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_bytes == 0) begin
            $display("vga_text_to_ansi_stream_unit verification clean");
        end else begin
            $display("vga_text_to_ansi_stream_unit verification failed");
        end
        $finish;
    end

endmodule
